// ===== src/mfs_pkg.sv =====
package mfs_pkg;

    // field widths of the stream words
    localparam int ID_W        = 4;
    localparam int BURST_W     = 16;
    localparam int SLICE_W     = 8;
    localparam int QUANT_W     = 8;
    localparam int CFG_INDEX_W = 8;

    // number of quantum registers, deeper levels share the last one
    localparam int QUANTUM_COUNT = 4;

    localparam logic [SLICE_W-1:0] SLICE_MAX = 8'd255;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET [QUANTUM_COUNT] =
        '{8'd2, 8'd4, 8'd6, 8'd10};

    // input kind carried in tuser
    localparam logic ACTION_ADMIT = 1'b0;
    localparam logic ACTION_TICK  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_QUANTUM_ONE   = 8'd0,
        CFG_QUANTUM_TWO   = 8'd1,
        CFG_QUANTUM_THREE = 8'd2,
        CFG_QUANTUM_FOUR  = 8'd3
    } cfg_index_t;

    // result kind carried in tuser
    typedef enum logic [1:0] {
        STAT_RAN      = 2'd0,
        STAT_IDLE     = 2'd1,
        STAT_ADMITTED = 2'd2,
        STAT_REJECTED = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FIFO,
        S_UPDATE,
        S_HOLD
    } state_t;

    // result word, ran_task in the lowest bits
    typedef struct packed {
        logic            demoted;
        logic            finished;
        logic [1:0]      ran_level;
        logic [ID_W-1:0] ran_task;
    } result_t;

endpackage

// ===== src/multilevel_feedback_scheduler.sv =====
// channel   dir  handshake                 payload
// s_        in   s_tvalid / s_tready       tuser: action; tdata: task_id, burst_length
// m_        out  m_tvalid / m_tready       tuser: status; tdata: ran_task, ran_level,
//                                          finished, demoted
// cfg_      in   cfg_valid / cfg_ready     cfg_index, cfg_data (quantum per level)
//
// admit and idle tick: the word is placed in the output register at once
// serving tick: queue store read, task store read, then update and write back
// a result that finds the output register full waits in the sequencer until it drains
// reset clears queue pointers, counts and active flags; both stores are unset until written
// the next word is taken after the previous one has left the sequencer
module multilevel_feedback_scheduler #(
    parameter int TASK_COUNT  = 16,
    parameter int LEVEL_COUNT = 4
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [3:0] task_id, [19:4] burst_length, [23:20] zero
    input  logic [0:0]  s_tuser,    // [0] action

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [3:0] ran_task, [5:4] ran_level, [6] finished,
                                    // [7] demoted
    output logic [1:0]  m_tuser,    // [1:0] status

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int TW         = $clog2(TASK_COUNT);
    localparam int CW         = $clog2(TASK_COUNT + 1);
    localparam int LW         = $clog2(LEVEL_COUNT);
    localparam int FIFO_DEPTH = LEVEL_COUNT * (2 ** TW);
    localparam int FIFO_AW    = LW + TW;
    localparam int TASK_DW    = mfs_pkg::BURST_W + mfs_pkg::SLICE_W;

    // control state
    mfs_pkg::state_t                 state_reg, state_next;
    logic [mfs_pkg::QUANT_W-1:0]     quanta_reg [mfs_pkg::QUANTUM_COUNT];
    logic [mfs_pkg::QUANT_W-1:0]     quanta_next [mfs_pkg::QUANTUM_COUNT];
    logic [TASK_COUNT-1:0]           active_reg, active_next;
    logic [TW-1:0]                   head_reg [LEVEL_COUNT];
    logic [TW-1:0]                   head_next [LEVEL_COUNT];
    logic [TW-1:0]                   tail_reg [LEVEL_COUNT];
    logic [TW-1:0]                   tail_next [LEVEL_COUNT];
    logic [CW-1:0]                   count_reg [LEVEL_COUNT];
    logic [CW-1:0]                   count_next [LEVEL_COUNT];
    logic [LW-1:0]                   cur_reg, cur_next;
    logic                            m_tvalid_reg, m_tvalid_next;

    // payload registers
    logic [LW-1:0]                   lvl_reg, lvl_next;
    logic [mfs_pkg::ID_W-1:0]        tid_reg, tid_next;
    mfs_pkg::result_t                res_data_reg, res_data_next;
    mfs_pkg::status_t                res_status_reg, res_status_next;
    mfs_pkg::result_t                m_tdata_reg, m_tdata_next;
    mfs_pkg::status_t                m_tuser_reg, m_tuser_next;

    // memory ports
    logic                            task_we, task_re;
    logic [TW-1:0]                   task_waddr, task_raddr;
    logic [TASK_DW-1:0]              task_wdata, task_rdata;
    logic                            fifo_we, fifo_re;
    logic [FIFO_AW-1:0]              fifo_waddr, fifo_raddr;
    logic [mfs_pkg::ID_W-1:0]        fifo_wdata, fifo_rdata;

    // input fields
    logic                            in_action;
    logic [mfs_pkg::ID_W-1:0]        in_id;
    logic [mfs_pkg::BURST_W-1:0]     in_burst;
    logic [TW-1:0]                   in_task_addr;
    logic                            admit_ok;

    // level scan
    logic                            scan_found;
    logic [LW-1:0]                   scan_lvl;
    logic [LW:0]                     scan_sum;

    // task update
    logic [mfs_pkg::BURST_W-1:0]     rem, rem_dec;
    logic [mfs_pkg::SLICE_W-1:0]     slc, slc_inc;
    logic [1:0]                      q_idx;
    logic [mfs_pkg::QUANT_W-1:0]     quantum;
    logic                            upd_finished, upd_demote;
    logic [LW-1:0]                   nxt_lvl;
    logic [TW-1:0]                   tid_addr;

    logic                            in_fire, out_free, deliver;
    mfs_pkg::result_t                deliver_data;
    mfs_pkg::status_t                deliver_status;

    function automatic logic [TW-1:0] ptr_inc(input logic [TW-1:0] p);
        return (p == TW'(TASK_COUNT - 1)) ? '0 : p + 1'b1;
    endfunction

    // per-task store: remaining ticks over slice used
    mfs_ram #(
        .WIDTH (TASK_DW),
        .DEPTH (TASK_COUNT)
    ) u_task_ram (
        .clk   (clk),
        .we    (task_we),
        .waddr (task_waddr),
        .wdata (task_wdata),
        .re    (task_re),
        .raddr (task_raddr),
        .rdata (task_rdata)
    );

    // queue store, one ring of TASK_COUNT slots per level
    mfs_ram #(
        .WIDTH (mfs_pkg::ID_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (fifo_wdata),
        .re    (fifo_re),
        .raddr (fifo_raddr),
        .rdata (fifo_rdata)
    );

    // handshakes
    assign in_action    = s_tuser[0];
    assign in_id        = s_tdata[3:0];
    assign in_burst     = s_tdata[19:4];
    assign in_task_addr = TW'(in_id);
    assign s_tready     = (state_reg == mfs_pkg::S_IDLE);
    assign in_fire      = s_tvalid && s_tready;
    assign out_free     = !m_tvalid_reg || m_tready;
    assign cfg_ready    = 1'b1;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign m_tuser      = m_tuser_reg;

    // admit check
    assign admit_ok = (32'(in_id) < 32'(TASK_COUNT)) && (in_burst != '0)
                      && !active_reg[in_task_addr];

    // cyclic search for a non-empty level starting at the current one
    always_comb
    begin
        scan_found = (count_reg[cur_reg] != '0);
        scan_lvl   = cur_reg;
        scan_sum   = '0;
        for (int i = 1; i <= LEVEL_COUNT; i++)
        begin
            scan_sum = {1'b0, cur_reg} + (LW+1)'(i);
            if (scan_sum >= (LW+1)'(LEVEL_COUNT))
            begin
                scan_sum = scan_sum - (LW+1)'(LEVEL_COUNT);
            end
            if (!scan_found && (count_reg[scan_sum[LW-1:0]] != '0))
            begin
                scan_found = 1'b1;
                scan_lvl   = scan_sum[LW-1:0];
            end
        end
    end

    // served task: one tick of service, slice check against the level quantum
    assign rem          = task_rdata[TASK_DW-1:mfs_pkg::SLICE_W];
    assign slc          = task_rdata[mfs_pkg::SLICE_W-1:0];
    assign rem_dec      = (rem != '0) ? rem - 1'b1 : rem;
    assign slc_inc      = (slc != mfs_pkg::SLICE_MAX) ? slc + 1'b1 : slc;
    assign q_idx        = (32'(lvl_reg) < mfs_pkg::QUANTUM_COUNT) ? 2'(lvl_reg)
                          : 2'(mfs_pkg::QUANTUM_COUNT - 1);
    assign quantum      = quanta_reg[q_idx];
    assign upd_finished = (rem_dec == '0);
    assign upd_demote   = !upd_finished && (slc_inc >= quantum);
    assign nxt_lvl      = (lvl_reg == LW'(LEVEL_COUNT - 1)) ? '0 : lvl_reg + 1'b1;
    assign tid_addr     = TW'(tid_reg);

    // sequencer, queue bookkeeping and output loading
    always_comb
    begin
        state_next      = state_reg;
        quanta_next     = quanta_reg;
        active_next     = active_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        cur_next        = cur_reg;
        lvl_next        = lvl_reg;
        tid_next        = tid_reg;
        res_data_next   = res_data_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        task_we    = 1'b0;
        task_waddr = tid_addr;
        task_wdata = '0;
        task_re    = 1'b0;
        task_raddr = TW'(fifo_rdata);
        fifo_we    = 1'b0;
        fifo_waddr = '0;
        fifo_wdata = tid_reg;
        fifo_re    = 1'b0;
        fifo_raddr = {scan_lvl, head_reg[scan_lvl]};

        deliver        = 1'b0;
        deliver_data   = '0;
        deliver_status = mfs_pkg::STAT_IDLE;

        // quantum register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                mfs_pkg::CFG_QUANTUM_ONE:   quanta_next[0] = cfg_data;
                mfs_pkg::CFG_QUANTUM_TWO:   quanta_next[1] = cfg_data;
                mfs_pkg::CFG_QUANTUM_THREE: quanta_next[2] = cfg_data;
                mfs_pkg::CFG_QUANTUM_FOUR:  quanta_next[3] = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            mfs_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_action == mfs_pkg::ACTION_ADMIT)
                    begin
                        deliver               = 1'b1;
                        deliver_data.ran_task = in_id;
                        deliver_status        = admit_ok ? mfs_pkg::STAT_ADMITTED
                                                         : mfs_pkg::STAT_REJECTED;
                        if (admit_ok)
                        begin
                            active_next[in_task_addr] = 1'b1;
                            task_we    = 1'b1;
                            task_waddr = in_task_addr;
                            task_wdata = {in_burst, {mfs_pkg::SLICE_W{1'b0}}};
                            // push at the tail of level one
                            if (count_reg[0] < CW'(TASK_COUNT))
                            begin
                                fifo_we       = 1'b1;
                                fifo_waddr    = {LW'(0), tail_reg[0]};
                                fifo_wdata    = in_id;
                                tail_next[0]  = ptr_inc(tail_reg[0]);
                                count_next[0] = count_reg[0] + 1'b1;
                            end
                            cur_next = '0;
                        end
                    end
                    else if (!scan_found)
                    begin
                        deliver        = 1'b1;
                        deliver_status = mfs_pkg::STAT_IDLE;
                    end
                    else
                    begin
                        // fetch the head task id of the serving level
                        cur_next   = scan_lvl;
                        lvl_next   = scan_lvl;
                        fifo_re    = 1'b1;
                        state_next = mfs_pkg::S_FIFO;
                    end
                end
            end

            mfs_pkg::S_FIFO:
            begin
                task_re    = 1'b1;
                tid_next   = fifo_rdata;
                state_next = mfs_pkg::S_UPDATE;
            end

            mfs_pkg::S_UPDATE:
            begin
                // write back only once the result has a place to go
                if (out_free)
                begin
                    task_we    = 1'b1;
                    task_waddr = tid_addr;
                    task_wdata = {rem_dec, upd_demote ? {mfs_pkg::SLICE_W{1'b0}} : slc_inc};

                    deliver                = 1'b1;
                    deliver_status         = mfs_pkg::STAT_RAN;
                    deliver_data.ran_task  = tid_reg;
                    deliver_data.ran_level = 2'(lvl_reg);
                    deliver_data.finished  = upd_finished;
                    deliver_data.demoted   = upd_demote;

                    if (upd_finished || upd_demote)
                    begin
                        if (upd_finished)
                        begin
                            active_next[tid_addr] = 1'b0;
                        end
                        if (count_reg[lvl_reg] != '0)
                        begin
                            head_next[lvl_reg]  = ptr_inc(head_reg[lvl_reg]);
                            count_next[lvl_reg] = count_reg[lvl_reg] - 1'b1;
                        end
                        // level drained, service moves on
                        if (count_reg[lvl_reg] <= CW'(1))
                        begin
                            cur_next = nxt_lvl;
                        end
                    end

                    if (upd_demote)
                    begin
                        if (count_reg[nxt_lvl] < CW'(TASK_COUNT))
                        begin
                            fifo_we             = 1'b1;
                            fifo_waddr          = {nxt_lvl, tail_reg[nxt_lvl]};
                            fifo_wdata          = tid_reg;
                            tail_next[nxt_lvl]  = ptr_inc(tail_reg[nxt_lvl]);
                            count_next[nxt_lvl] = count_reg[nxt_lvl] + 1'b1;
                        end
                        // wrap from the last level back to level one
                        if (nxt_lvl == '0)
                        begin
                            cur_next = '0;
                        end
                    end
                    state_next = mfs_pkg::S_IDLE;
                end
            end

            mfs_pkg::S_HOLD:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_data_reg;
                    m_tuser_next  = res_status_reg;
                    state_next    = mfs_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mfs_pkg::S_IDLE;
            end
        endcase

        // result goes straight to the output register or waits in the hold
        if (deliver)
        begin
            if (out_free)
            begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = deliver_data;
                m_tuser_next  = deliver_status;
            end
            else
            begin
                res_data_next   = deliver_data;
                res_status_next = deliver_status;
                state_next      = mfs_pkg::S_HOLD;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mfs_pkg::S_IDLE;
            quanta_reg   <= mfs_pkg::QUANTUM_RESET;
            active_reg   <= '0;
            head_reg     <= '{default: '0};
            tail_reg     <= '{default: '0};
            count_reg    <= '{default: '0};
            cur_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            quanta_reg   <= quanta_next;
            active_reg   <= active_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            cur_reg      <= cur_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lvl_reg        <= lvl_next;
        tid_reg        <= tid_next;
        res_data_reg   <= res_data_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

endmodule

// ===== src/mfs_ram.sv =====
module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mfs_checker.sv =====
module mfs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // level, finished and demoted only on a served tick
    a_non_ran_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != mfs_pkg::STAT_RAN) |-> (m_tdata[7:4] == 4'd0))
        else $error("service fields set on a word that is not a served tick");

    // a served task either finishes or is demoted, never both
    a_ran_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == mfs_pkg::STAT_RAN) |-> !(m_tdata[6] && m_tdata[7]))
        else $error("task both finished and demoted");

    // idle word carries nothing
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == mfs_pkg::STAT_IDLE) |-> (m_tdata == 8'd0))
        else $error("idle word with nonzero fields");

endmodule

bind multilevel_feedback_scheduler mfs_checker u_mfs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
